// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level of the joint constraint block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BGJC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BGJC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BGJC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BGJC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/bgjc_pkg.sv -----
// Shared types and constants for the joint constraint block.
package bgjc_pkg;
  localparam int MAX_JOINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_JOINTS);
  localparam int COORD_W    = 32;
  localparam int CFG_W      = 31;
  localparam int RAD_W      = 66;
  localparam int ROOT_W     = 33;
  localparam int QUO_W      = 49;

  typedef struct packed {
    logic start;
    logic is_div;
  } bgjc_ireq_t;
endpackage

// ----- hdl/bgjc_iter.sv -----
// Iterative square root and reciprocal unit sharing one subtractor.
module bgjc_iter import bgjc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bgjc_ireq_t        req,
  input  logic [RAD_W-1:0]  rad,
  input  logic [ROOT_W-1:0] dvs,
  output logic              busy,
  output logic              done,
  output logic [QUO_W-1:0]  res
);
  logic              busy_r, done_r, div_r;
  logic [5:0]        cnt_r;
  logic [35:0]       rem_r;
  logic [QUO_W-1:0]  q_r;
  logic [RAD_W-1:0]  sh_r;
  logic [ROOT_W-1:0] d_r;
  logic [35:0]       remsh, trial, rem_nxt;
  logic              ge;
  logic [5:0]        last_cnt;

  always_comb begin
    if (div_r) begin
      remsh    = {rem_r[34:0], (cnt_r == 6'd0)};
      trial    = {3'b0, d_r};
      last_cnt = 6'(QUO_W - 1);
    end else begin
      remsh    = {rem_r[33:0], sh_r[RAD_W-1 -: 2]};
      trial    = {1'b0, q_r[ROOT_W-1:0], 2'b01};
      last_cnt = 6'(RAD_W / 2 - 1);
    end
    ge      = remsh >= trial;
    rem_nxt = ge ? remsh - trial : remsh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == last_cnt) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      cnt_r <= '0;
      rem_r <= '0;
      q_r   <= '0;
      sh_r  <= rad;
      d_r   <= dvs;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[QUO_W-2:0], ge};
      sh_r  <= {sh_r[RAD_W-3:0], 2'b00};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = q_r;
endmodule

// ----- hdl/bezier_g1_joint_constraint_top.sv -----
// Top level of the cubic Bezier G1 joint constraint block.
// A joint that is not G1 runs the multiply sequence only (one 32x32 multiplier, 22
// products); a degenerate G1 joint adds two 33-step square roots, and a full joint
// adds two 49-step divisions on one iterative unit.
// A new joint is taken only in the idle state; a held result stalls the next joint.
// Synchronous active-low reset clears the counters, control and minimum length, and sets the cross limit to one.
`include "assert_macros.svh"
module bezier_g1_joint_constraint_top import bgjc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // prev_x, prev_y, prev_z, anchor_x, anchor_y, anchor_z, next_x, next_y, next_z
  input  logic [287:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_block, anchor_index, center_coef, left_coef, right_coef, zero pad
  output logic [215:0] out_tdata,
  // joint_is_g1, degenerate
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CMP = 4'd2, S_SQL = 4'd3,
                         S_SQR = 4'd4, S_DEG = 4'd5, S_DVL = 4'd6, S_DVR = 4'd7,
                         S_OUT = 4'd8;
  localparam logic [2:0] K_LL = 3'd0, K_RR = 3'd1, K_CR0 = 3'd2, K_CR1 = 3'd3,
                         K_SQ0 = 3'd4, K_SQ1 = 3'd5, K_SQ2 = 3'd6, K_THR = 3'd7;
  localparam logic [1:0] CFG_LIMIT = 2'd0, CFG_MINLEN = 2'd1;
  localparam logic [4:0] ST_LAST = 5'd21;

  logic [3:0]          state_r;
  logic [4:0]          st_r;
  logic                ph_r, lau_r, last_r, fail_r, g1_r, deg_r;
  logic [COORD_W-1:0]  ltm_r [3];
  logic [COORD_W-1:0]  rtm_r [3];
  logic [2:0]          lts_r, rts_r;
  logic [RAD_W-1:0]    ll_r, rr_r;
  logic signed [66:0]  cr_r;
  logic [97:0]         cs_r;
  logic [61:0]         thr_r;
  logic [63:0]         prod_r;
  logic [ROOT_W-1:0]   l_r, r_r;
  logic [QUO_W-1:0]    il_r, ir_r;
  logic [CFG_W-1:0]    limit_r, minlen_r;
  logic [CNT_W-1:0]    rowcnt_r, pos_r;
  logic                out_valid_r;
  logic [215:0]        out_data_r;
  logic [1:0]          out_user_r;

  logic [COORD_W-1:0]  lt_m [3];
  logic [COORD_W-1:0]  rt_m [3];
  logic [2:0]          lt_s, rt_s;
  logic [31:0]         opa, opb;
  logic                sgn;
  logic [2:0]          kind;
  logic signed [66:0]  psg, crm;
  logic                big;
  logic [23:0]         ml, mh;
  bgjc_ireq_t          ireq;
  logic                ibusy, idone;
  logic [QUO_W-1:0]    ires;
  logic                accept, out_free;
  logic [CNT_W:0]      pos1;
  logic [11:0]         anchor_num;
  logic                coef_ok;
  logic                deg_now;
  logic [62:0]         center;
  logic [63:0]         left_c, right_c;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [32:0] dl, dr;
      dl = {in_tdata[96+32*k+31], in_tdata[96+32*k +: 32]}
         - {in_tdata[32*k+31], in_tdata[32*k +: 32]};
      dr = {in_tdata[96+32*k+31], in_tdata[96+32*k +: 32]}
         - {in_tdata[192+32*k+31], in_tdata[192+32*k +: 32]};
      lt_s[k] = dl[32];
      rt_s[k] = dr[32];
      lt_m[k] = dl[32] ? 32'(-dl) : dl[31:0];
      rt_m[k] = dr[32] ? 32'(-dr) : dr[31:0];
    end
  end

  assign crm = cr_r[66] ? -cr_r : cr_r;
  assign big = |crm[66:48];
  assign ml  = crm[23:0];
  assign mh  = crm[47:24];

  always_comb begin
    opa  = '0;
    opb  = '0;
    sgn  = 1'b0;
    kind = K_LL;
    unique case (st_r)
      5'd0:  begin opa = ltm_r[0]; opb = ltm_r[0]; kind = K_LL; end
      5'd1:  begin opa = ltm_r[1]; opb = ltm_r[1]; kind = K_LL; end
      5'd2:  begin opa = ltm_r[2]; opb = ltm_r[2]; kind = K_LL; end
      5'd3:  begin opa = rtm_r[0]; opb = rtm_r[0]; kind = K_RR; end
      5'd4:  begin opa = rtm_r[1]; opb = rtm_r[1]; kind = K_RR; end
      5'd5:  begin opa = rtm_r[2]; opb = rtm_r[2]; kind = K_RR; end
      5'd6:  begin opa = ltm_r[1]; opb = rtm_r[2]; sgn = lts_r[1] ^ rts_r[2]; kind = K_CR0; end
      5'd7:  begin opa = ltm_r[2]; opb = rtm_r[1]; sgn = lts_r[2] ^ rts_r[1]; kind = K_CR1; end
      5'd11: begin opa = ltm_r[2]; opb = rtm_r[0]; sgn = lts_r[2] ^ rts_r[0]; kind = K_CR0; end
      5'd12: begin opa = ltm_r[0]; opb = rtm_r[2]; sgn = lts_r[0] ^ rts_r[2]; kind = K_CR1; end
      5'd16: begin opa = ltm_r[0]; opb = rtm_r[1]; sgn = lts_r[0] ^ rts_r[1]; kind = K_CR0; end
      5'd17: begin opa = ltm_r[1]; opb = rtm_r[0]; sgn = lts_r[1] ^ rts_r[0]; kind = K_CR1; end
      5'd8, 5'd13, 5'd18: begin opa = {8'b0, ml}; opb = {8'b0, ml}; kind = K_SQ0; end
      5'd9, 5'd14, 5'd19: begin opa = {8'b0, mh}; opb = {8'b0, ml}; kind = K_SQ1; end
      5'd10, 5'd15, 5'd20: begin opa = {8'b0, mh}; opb = {8'b0, mh}; kind = K_SQ2; end
      5'd21: begin opa = {1'b0, limit_r}; opb = {1'b0, limit_r}; kind = K_THR; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign psg = sgn ? -{3'b0, prod_r} : {3'b0, prod_r};

  always_comb begin
    ireq.start  = !lau_r && (state_r == S_SQL || state_r == S_SQR ||
                             state_r == S_DVL || state_r == S_DVR);
    ireq.is_div = (state_r == S_DVL || state_r == S_DVR);
  end

  bgjc_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .rad   ((state_r == S_SQL) ? ll_r : rr_r),
    .dvs   ((state_r == S_DVL) ? l_r : r_r),
    .busy  (ibusy),
    .done  (idone),
    .res   (ires)
  );

  assign deg_now    = l_r <= {2'b0, minlen_r} || r_r <= {2'b0, minlen_r} ||
                      l_r == '0 || r_r == '0;
  assign coef_ok    = g1_r && !deg_r;
  assign center     = coef_ok ? 63'({14'b0, il_r} + {14'b0, ir_r}) : '0;
  assign left_c     = coef_ok ? -{15'b0, il_r} : '0;
  assign right_c    = coef_ok ? -{15'b0, ir_r} : '0;
  assign pos1       = {1'b0, pos_r} + (CNT_W+1)'(1);
  assign anchor_num = 12'({pos1, 1'b0}) + 12'(pos1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= '0;
      ph_r        <= 1'b0;
      lau_r       <= 1'b0;
      limit_r     <= CFG_W'(1);
      minlen_r    <= '0;
      rowcnt_r    <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LIMIT) limit_r <= cfg_data;
        else if (cfg_index == CFG_MINLEN) minlen_r <= cfg_data;
      end
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (ireq.start) lau_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MUL;
            st_r    <= '0;
            ph_r    <= 1'b0;
          end
        end
        S_MUL: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (st_r == ST_LAST) state_r <= S_CMP;
            else st_r <= st_r + 5'd1;
          end
        end
        S_CMP: state_r <= (!fail_r && cs_r < {4'b0, thr_r, 32'b0}) ? S_SQL : S_OUT;
        S_SQL: if (idone) begin lau_r <= 1'b0; state_r <= S_SQR; end
        S_SQR: if (idone) begin lau_r <= 1'b0; state_r <= S_DEG; end
        S_DEG: state_r <= deg_now ? S_OUT : S_DVL;
        S_DVL: if (idone) begin lau_r <= 1'b0; state_r <= S_DVR; end
        S_DVR: if (idone) begin lau_r <= 1'b0; state_r <= S_OUT; end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (last_r) begin
              rowcnt_r <= '0;
              pos_r    <= '0;
            end else begin
              pos_r <= pos_r + CNT_W'(1);
              if (g1_r) rowcnt_r <= rowcnt_r + CNT_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ltm_r  <= lt_m;
      rtm_r  <= rt_m;
      lts_r  <= lt_s;
      rts_r  <= rt_s;
      last_r <= in_tlast;
      ll_r   <= '0;
      rr_r   <= '0;
      cs_r   <= '0;
      fail_r <= 1'b0;
      g1_r   <= 1'b0;
      deg_r  <= 1'b0;
    end
    if (state_r == S_MUL) begin
      if (!ph_r) begin
        prod_r <= opa * opb;
      end else begin
        case (kind)
          K_LL:  ll_r  <= ll_r + {2'b0, prod_r};
          K_RR:  rr_r  <= rr_r + {2'b0, prod_r};
          K_CR0: cr_r  <= psg;
          K_CR1: cr_r  <= cr_r - psg;
          K_SQ0: begin
            cs_r   <= cs_r + {34'b0, prod_r};
            fail_r <= fail_r | big;
          end
          K_SQ1: cs_r  <= cs_r + {9'b0, prod_r, 25'b0};
          K_SQ2: cs_r  <= cs_r + {prod_r[49:0], 48'b0};
          K_THR: thr_r <= prod_r[61:0];
          default: thr_r <= thr_r;
        endcase
      end
    end
    if (state_r == S_CMP) g1_r <= !fail_r && cs_r < {4'b0, thr_r, 32'b0};
    if (state_r == S_SQL && idone) l_r <= ires[ROOT_W-1:0];
    if (state_r == S_SQR && idone) r_r <= ires[ROOT_W-1:0];
    if (state_r == S_DEG) deg_r <= deg_now;
    if (state_r == S_DVL && idone) il_r <= ires;
    if (state_r == S_DVR && idone) ir_r <= ires;
    if (state_r == S_OUT && out_free) begin
      out_user_r <= {g1_r && deg_r, g1_r};
      out_data_r <= {3'b0, right_c, left_c, center, anchor_num,
                     g1_r ? rowcnt_r : CNT_W'(0)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `BGJC_ASSERT_NOW(a_deg_g1, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0], "degenerate without G1")
  `BGJC_ASSERT_NOW(a_nog1_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[84:0] == {63'b0, out_tdata[21:10], 10'b0}, "non-G1 result carries coefficients or row")
  `BGJC_ASSERT_NOW(a_start_idle, clk, rst_n, ireq.start, !ibusy, "iterative unit restarted while busy")
  `BGJC_ASSERT_NEXT(a_accept_mul, clk, rst_n, accept, state_r == S_MUL && st_r == 5'd0, "accepted joint did not enter the multiply sequence")
endmodule

// ----- verif/bezier_g1_joint_constraint_top_test.sv -----
// Randomized scoreboard testbench for the Bezier G1 joint constraint block.
module bezier_g1_joint_constraint_top_test import bgjc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_CROSS_LIMIT = 0;
  localparam int CFG_MIN_LENGTH  = 1;
  localparam int CFG_SPARE_A     = 2;
  localparam int CFG_SPARE_B     = 3;
  localparam int SETTLE_CYCLES   = 300;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [30:0] CFG_MAX = 31'h7FFFFFFF;

  typedef enum int { JOINT_NOISE, JOINT_LINE, JOINT_NEAR, JOINT_FLAT } joint_kind_t;

  typedef struct {
    logic signed [31:0] pt[9];
    logic               last;
  } joint_t;

  typedef struct {
    logic        is_g1;
    logic        degen;
    logic [9:0]  row;
    logic [11:0] anchor;
    logic [62:0] center;
    logic [63:0] left;
    logic [63:0] right;
  } joint_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [215:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  joint_t pending_joints[$];
  joint_result_t expected_results[$];

  logic [30:0] cross_limit;
  logic [30:0] min_length;
  logic [9:0] rows_taken;
  logic [9:0] joint_pos;

  int mismatches = 0;
  int joints_sent = 0;
  int results_seen = 0;
  int g1_seen = 0;
  int degen_seen = 0;
  longint cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit no_idle = 1'b0;

  bezier_g1_joint_constraint_top dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // square of (a*b - c*d), with the 64-bit wrap of each product magnitude
  function automatic bit cross_square(longint a, longint b, longint c, longint d,
                                      output logic [127:0] sq);
    logic [63:0] m1, m2, m;
    logic [64:0] s;
    bit n1, n2;
    n1 = (a < 0) != (b < 0);
    n2 = !((c < 0) != (d < 0));
    m1 = magnitude(a) * magnitude(b);
    m2 = magnitude(c) * magnitude(d);
    sq = '0;
    if (n1 == n2) begin
      s = {1'b0, m1} + {1'b0, m2};
      if (s[64]) return 1'b0;
      m = s[63:0];
    end else begin
      m = (m1 >= m2) ? m1 - m2 : m2 - m1;
    end
    if (m >= 64'h0001_0000_0000_0000) return 1'b0;
    sq = {64'd0, m} * {64'd0, m};
    return 1'b1;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0] res, c;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  function automatic joint_result_t judge_joint(joint_t j);
    joint_result_t r;
    longint lt[3], rt[3];
    logic [127:0] ll, rr, cs, t, thr;
    logic [63:0] l, rl, il, ir, l2;
    bit g1;
    ll = '0;
    rr = '0;
    cs = '0;
    g1 = 1'b1;
    for (int k = 0; k < 3; k++) begin
      lt[k] = longint'(j.pt[3+k]) - longint'(j.pt[k]);
      rt[k] = longint'(j.pt[3+k]) - longint'(j.pt[6+k]);
      ll += {64'd0, magnitude(lt[k])} * {64'd0, magnitude(lt[k])};
      rr += {64'd0, magnitude(rt[k])} * {64'd0, magnitude(rt[k])};
    end
    for (int k = 0; k < 3 && g1; k++) begin
      if (cross_square(lt[(k+1)%3], rt[(k+2)%3], lt[(k+2)%3], rt[(k+1)%3], t)) cs += t;
      else g1 = 1'b0;
    end
    l2 = {33'd0, cross_limit} * {33'd0, cross_limit};
    thr = {32'd0, l2, 32'd0};
    if (g1 && !(cs < thr)) g1 = 1'b0;
    r = '{default: '0};
    r.is_g1 = g1;
    r.anchor = 12'(3 * (int'(joint_pos) + 1));
    if (g1) begin
      l = floor_root(ll);
      rl = floor_root(rr);
      r.degen = l <= min_length || rl <= min_length || l == 0 || rl == 0;
      r.row = rows_taken;
      if (!r.degen) begin
        il = (64'd1 << 48) / l;
        ir = (64'd1 << 48) / rl;
        r.center = 63'(il + ir);
        r.left = 64'd0 - il;
        r.right = 64'd0 - ir;
      end
      rows_taken = rows_taken + 10'd1;
    end
    joint_pos = joint_pos + 10'd1;
    if (j.last) begin
      rows_taken = '0;
      joint_pos = '0;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [287:0] pack_joint(joint_t j);
    logic [287:0] d;
    for (int k = 0; k < 9; k++) d[32*k +: 32] = j.pt[k];
    return d;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_tvalid <= 1'b0;
      send_gap <= draw_gap();
    end else if (!in_tvalid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_joints.size() > 0) begin
        joint_t j;
        j = pending_joints.pop_front();
        in_tdata <= pack_joint(j);
        in_tlast <= j.last;
        in_tvalid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      joint_t j;
      for (int k = 0; k < 9; k++) j.pt[k] = in_tdata[32*k +: 32];
      j.last = in_tlast;
      expected_results.push_back(judge_joint(j));
      joints_sent++;
    end
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("result %0d: %s got %h expected %h", results_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        joint_result_t w;
        if (expected_results.size() == 0) begin
          report("transfer with no joint pending", 64'd1, 64'd0);
        end else begin
          w = expected_results.pop_front();
          if (out_tuser[0] !== w.is_g1)
            report("joint_is_g1", 64'(out_tuser[0]), 64'(w.is_g1));
          if (out_tuser[1] !== w.degen)
            report("degenerate", 64'(out_tuser[1]), 64'(w.degen));
          if (out_tdata[9:0] !== w.row)
            report("row_block", 64'(out_tdata[9:0]), 64'(w.row));
          if (out_tdata[21:10] !== w.anchor)
            report("anchor_index", 64'(out_tdata[21:10]), 64'(w.anchor));
          if (out_tdata[84:22] !== w.center)
            report("center_coef", 64'(out_tdata[84:22]), 64'(w.center));
          if (out_tdata[148:85] !== w.left) report("left_coef", out_tdata[148:85], w.left);
          if (out_tdata[212:149] !== w.right)
            report("right_coef", out_tdata[212:149], w.right);
          if (w.is_g1) g1_seen++;
          if (w.degen) degen_seen++;
        end
        results_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        recv_gap <= draw_gap();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_joints.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [30:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CROSS_LIMIT) cross_limit = value;
    else if (idx == CFG_MIN_LENGTH) min_length = value;
  endtask

  function automatic logic signed [31:0] rand_span(int lim);
    return 32'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic joint_t make_joint(joint_kind_t kind, bit last);
    joint_t j;
    int d[3];
    int a, b;
    j.last = last;
    for (int k = 0; k < 9; k++) j.pt[k] = $urandom;
    if (kind == JOINT_NOISE) return j;
    a = $urandom_range(0, 1 << 14);
    b = $urandom_range(0, 1 << 14);
    for (int k = 0; k < 3; k++) begin
      d[k] = rand_span(1 << 12);
      j.pt[3+k] = rand_span(1 << 30);
      j.pt[k] = j.pt[3+k] - a * d[k];
      j.pt[6+k] = j.pt[3+k] + b * d[k];
      if (kind == JOINT_NEAR) j.pt[6+k] = j.pt[6+k] + rand_span(255);
    end
    if (kind == JOINT_FLAT) begin
      if ($urandom_range(0, 1)) for (int k = 0; k < 3; k++) j.pt[k] = j.pt[3+k];
      else for (int k = 0; k < 3; k++) j.pt[6+k] = j.pt[3+k];
    end
    return j;
  endfunction

  function automatic joint_t fixed_joint(logic signed [31:0] p, logic signed [31:0] an,
                                         logic signed [31:0] n, bit last);
    joint_t j;
    for (int k = 0; k < 3; k++) begin
      j.pt[k] = p;
      j.pt[3+k] = an;
      j.pt[6+k] = n;
    end
    j.last = last;
    return j;
  endfunction

  task automatic queue_random(int count, bit allow_last);
    joint_kind_t kind;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = pick < 55 ? JOINT_LINE : pick < 72 ? JOINT_NEAR : pick < 85 ? JOINT_FLAT
           : JOINT_NOISE;
      pending_joints.push_back(make_joint(kind, allow_last && $urandom_range(0, 19) == 0));
    end
  endtask

  initial begin
    cross_limit = 31'd1;
    min_length = '0;
    rows_taken = '0;
    joint_pos = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero tangents, wrapped products, final joint
    pending_joints.push_back(fixed_joint(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0));
    pending_joints.push_back(fixed_joint(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0));
    pending_joints.push_back(fixed_joint(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0));
    pending_joints.push_back(fixed_joint(0, 0, 0, 0));
    pending_joints.push_back(fixed_joint(-32'sd65536, 0, 32'sd65536, 0));
    pending_joints.push_back(fixed_joint(-32'sd1, 0, 32'sd1, 1));
    pending_joints.push_back(fixed_joint(32'sd1, 0, -32'sd1, 0));
    for (int k = 0; k < 4; k++) begin
      pending_joints.push_back(make_joint(JOINT_LINE, 0));
      pending_joints.push_back(make_joint(JOINT_FLAT, 0));
      pending_joints.push_back(make_joint(JOINT_NEAR, 0));
      pending_joints.push_back(make_joint(JOINT_NOISE, k == 3));
    end
    wait_idle();

    write_reg(CFG_CROSS_LIMIT, 31'd0);
    write_reg(CFG_SPARE_A, 31'($urandom));
    queue_random(60, 1);
    wait_idle();

    write_reg(CFG_CROSS_LIMIT, CFG_MAX);
    write_reg(CFG_MIN_LENGTH, CFG_MAX);
    write_reg(CFG_SPARE_B, 31'($urandom));
    no_idle = 1'b1;
    // long curve without a final joint so both counters run high
    for (int i = 0; i < 400; i++) pending_joints.push_back(make_joint(JOINT_LINE, 0));
    wait_idle();
    no_idle = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CROSS_LIMIT, ph == 0 ? CFG_MAX : 31'($urandom_range(1, 1 << 20)));
      write_reg(CFG_MIN_LENGTH, ph == 0 ? 31'd0 : 31'($urandom_range(0, 1 << 22)));
      no_idle = (ph == 2);
      queue_random(40, 1);
      wait_idle();
    end
    no_idle = 1'b0;

    $display("%0d joints sent, %0d results checked (%0d G1, %0d degenerate)",
             joints_sent, results_seen, g1_seen, degen_seen);
    $display("covered zero and maximum limits, a long curve, and end-of-curve resets");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
